/* rtl/cslc_pkg.sv */
package cslc_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 32;

  // Field widths of the result word.
  localparam int OUT_W   = 32;
  localparam int PCT_W   = 7;
  localparam int FIELD_W = 6 * OUT_W + 2 * PCT_W;
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

  localparam int BYTE_W = 8;
  localparam int PREV_W = BYTE_W + 1;

  // Previous-byte marker after reset or after a file ends; it matches no byte.
  localparam logic [PREV_W-1:0] NO_BYTE = 9'h100;

  localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_BSPACE  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_BELL    = 8'h07;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  function automatic logic is_white(input logic [BYTE_W-1:0] b);
    return (b == CH_TAB) || (b == CH_VTAB) || (b == CH_BSPACE) || (b == CH_CR) ||
           (b == CH_FF) || (b == CH_BELL) || (b == CH_SPACE) || (b == CH_NEWLINE);
  endfunction

endpackage

/* rtl/c_source_line_counter_top.sv */
// Byte words are taken one per cycle while s_tready is high and produce no result word.
// An end word starts one shared restoring divider that yields one quotient bit a cycle
// and runs three divisions in turn. s_tready is low from the end word until its result
// is loaded into the output register, and the result then waits there for m_tready.
// rst is synchronous and active high; it clears all byte and line counters, modes and m_tvalid.
module c_source_line_counter_top #(
  parameter int COUNT_WIDTH = cslc_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // char_byte[7:0]
  input  logic [cslc_pkg::BYTE_W-1:0]  s_tdata,
  // end_marker
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // code_lines[31:0], blank_lines[63:32], code_bytes[95:64], white_bytes[127:96],
  // comment_bytes[159:128], avg_line_bytes[191:160], code_percent[198:192],
  // code_percent_no_comment[205:199], zero fill[207:206]
  output logic [cslc_pkg::TDATA_W-1:0] m_tdata
);

  localparam int CW    = COUNT_WIDTH;
  localparam int NW    = CW + 7;        // numerator: code bytes times 100
  localparam int DW    = CW + 2;        // denominator: sum of three counters
  localparam int CNT_W = $clog2(NW);
  localparam int OW    = cslc_pkg::OUT_W;
  localparam int PW    = cslc_pkg::PCT_W;

  typedef enum logic [2:0] {S_RUN, S_PREP, S_LOAD, S_DIV, S_DONE} state_t;
  typedef enum logic [1:0] {SEL_AVG, SEL_PCT, SEL_PCT_NC} sel_t;

  state_t state;
  sel_t   div_sel;

  logic [cslc_pkg::PREV_W-1:0] prev_byte;
  logic                        in_comment;
  logic                        line_has_code;
  logic [CW-1:0]               code_lines;
  logic [CW-1:0]               blank_lines;
  logic [CW-1:0]               code_bytes;
  logic [CW-1:0]               white_bytes;
  logic [CW-1:0]               comment_bytes;

  logic                        in_comment_next;
  logic                        line_has_code_next;
  logic [CW-1:0]               code_lines_next;
  logic [CW-1:0]               blank_lines_next;
  logic [CW-1:0]               code_bytes_next;
  logic [CW-1:0]               white_bytes_next;
  logic [CW-1:0]               comment_bytes_next;

  logic [NW-1:0]               c100;
  logic [DW-1:0]               total;
  logic [DW-1:0]               code_white;

  logic [NW-1:0]               num;
  logic [DW-1:0]               den;
  logic [DW-1:0]               rem;
  logic [CNT_W-1:0]            step;

  logic [OW-1:0]               avg_res;
  logic [PW-1:0]               pct_res;
  logic [PW-1:0]               pct_nc_res;

  logic [DW:0]                 trial;
  logic                        fits;
  logic [DW:0]                 diff;
  logic [NW-1:0]               quo_next;
  logic [NW-1:0]               quo_final;

  logic [cslc_pkg::BYTE_W-1:0] b;
  logic                        in_fire;
  logic                        is_slash_prev;
  logic                        is_star_prev;

  assign s_tready = (state == S_RUN);
  assign in_fire  = s_tvalid && s_tready;
  assign b        = s_tdata;

  assign is_slash_prev = (prev_byte == {1'b0, cslc_pkg::CH_SLASH});
  assign is_star_prev  = (prev_byte == {1'b0, cslc_pkg::CH_STAR});

  // Byte classification; counters saturate at all ones, the take-back at zero.
  always_comb begin
    in_comment_next    = in_comment;
    line_has_code_next = line_has_code;
    code_lines_next    = code_lines;
    blank_lines_next   = blank_lines;
    code_bytes_next    = code_bytes;
    white_bytes_next   = white_bytes;
    comment_bytes_next = comment_bytes;
    if (!in_comment) begin
      if (b == cslc_pkg::CH_STAR && is_slash_prev) begin
        in_comment_next = 1'b1;
        if (code_bytes != '0) begin
          code_bytes_next = code_bytes - CW'(1);
        end
      end else if (cslc_pkg::is_white(b)) begin
        if (b == cslc_pkg::CH_NEWLINE) begin
          if (line_has_code) begin
            line_has_code_next = 1'b0;
            if (!(&code_lines)) begin
              code_lines_next = code_lines + CW'(1);
            end
          end else if (!(&blank_lines)) begin
            blank_lines_next = blank_lines + CW'(1);
          end
        end
        if (!(&white_bytes)) begin
          white_bytes_next = white_bytes + CW'(1);
        end
      end else begin
        line_has_code_next = 1'b1;
        if (!(&code_bytes)) begin
          code_bytes_next = code_bytes + CW'(1);
        end
      end
    end else begin
      if (b == cslc_pkg::CH_SLASH && is_star_prev) begin
        in_comment_next = 1'b0;
      end else if (!(&comment_bytes)) begin
        comment_bytes_next = comment_bytes + CW'(1);
      end
    end
  end

  // One restoring step: bring down the next numerator bit and try a subtract.
  always_comb begin
    trial     = {rem, num[NW-1]};
    diff      = trial - {1'b0, den};
    fits      = (trial >= {1'b0, den});
    quo_next  = {num[NW-2:0], fits};
    quo_final = (den == '0) ? '0 : quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RUN;
      div_sel       <= SEL_AVG;
      prev_byte     <= cslc_pkg::NO_BYTE;
      in_comment    <= 1'b0;
      line_has_code <= 1'b0;
      code_lines    <= '0;
      blank_lines   <= '0;
      code_bytes    <= '0;
      white_bytes   <= '0;
      comment_bytes <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // In S_DONE a taken result is replaced by the new one below.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (in_fire) begin
            if (s_tuser) begin
              state <= S_PREP;
            end else begin
              prev_byte     <= {1'b0, b};
              in_comment    <= in_comment_next;
              line_has_code <= line_has_code_next;
              code_lines    <= code_lines_next;
              blank_lines   <= blank_lines_next;
              code_bytes    <= code_bytes_next;
              white_bytes   <= white_bytes_next;
              comment_bytes <= comment_bytes_next;
            end
          end
        end
        S_PREP: begin
          // Times 100 as 64 + 32 + 4.
          c100       <= (NW'(code_bytes) << 6) + (NW'(code_bytes) << 5) +
                        (NW'(code_bytes) << 2);
          total      <= DW'(code_bytes) + DW'(white_bytes) + DW'(comment_bytes);
          code_white <= DW'(code_bytes) + DW'(white_bytes);
          div_sel    <= SEL_AVG;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          rem  <= '0;
          step <= '0;
          case (div_sel)
            SEL_AVG: begin
              num <= NW'(code_bytes);
              den <= DW'(code_lines);
            end
            SEL_PCT: begin
              num <= c100;
              den <= total;
            end
            SEL_PCT_NC: begin
              num <= c100;
              den <= code_white;
            end
            default: begin
              num <= c100;
              den <= code_white;
            end
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          num  <= quo_next;
          rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
          step <= step + CNT_W'(1);
          if (step == CNT_W'(NW - 1)) begin
            case (div_sel)
              SEL_AVG: begin
                avg_res <= OW'(quo_final);
                div_sel <= SEL_PCT;
                state   <= S_LOAD;
              end
              SEL_PCT: begin
                pct_res <= PW'(quo_final);
                div_sel <= SEL_PCT_NC;
                state   <= S_LOAD;
              end
              default: begin
                pct_nc_res <= PW'(quo_final);
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          // Wait for the output register to free up, then start the next file.
          if (!m_tvalid || m_tready) begin
            m_tdata       <= {(cslc_pkg::TDATA_W - cslc_pkg::FIELD_W)'(0), pct_nc_res,
                              pct_res, avg_res, OW'(comment_bytes), OW'(white_bytes),
                              OW'(code_bytes), OW'(blank_lines), OW'(code_lines)};
            m_tvalid      <= 1'b1;
            prev_byte     <= cslc_pkg::NO_BYTE;
            in_comment    <= 1'b0;
            line_has_code <= 1'b0;
            code_lines    <= '0;
            blank_lines   <= '0;
            code_bytes    <= '0;
            white_bytes   <= '0;
            comment_bytes <= '0;
            state         <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_end_drops_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("ready stayed high after an end word");

  a_comment_keeps_line_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && in_comment) |=> (line_has_code == $past(line_has_code)))
    else $error("line flag changed inside a comment");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && den != '0) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6*OW+PW-1:6*OW] <= cslc_pkg::PCT_MAX &&
                  m_tdata[6*OW+2*PW-1:6*OW+PW] <= cslc_pkg::PCT_MAX))
    else $error("code percentage above 100");
`endif

endmodule
